// File: hdl/srrs_pkg.sv
// ----------------------------------------------------------------------------
// srrs_pkg
// Shared types and character codes for the small residue run scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package srrs_pkg;

    // scan phases, one-hot
    typedef enum logic [6:0] {
        PH_FIRST  = 7'b0000001,
        PH_NAME   = 7'b0000010,
        PH_CHAIN  = 7'b0000100,
        PH_SKIP   = 7'b0001000,
        PH_SECOND = 7'b0010000,
        PH_THIRD  = 7'b0100000,
        PH_FOURTH = 7'b1000000
    } t_phase;

    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_HEADER  = 8'h3E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    localparam logic [1:0] BACK_TWO   = 2'd2;
    localparam logic [1:0] BACK_THREE = 2'd3;

    localparam int START_BITS = 20;

    // one record leaving the step logic
    typedef struct packed {
        logic                  vld;
        logic [31:0]           residues;
        logic [2:0]            length;
        logic [START_BITS-1:0] start;
    } t_rec;

    function automatic logic is_small(input logic [7:0] c);
        return (c == CH_G) || (c == CH_A) || (c == CH_S) || (c == CH_T) || (c == CH_C);
    endfunction

endpackage

`default_nettype wire

// File: hdl/srrs_step.sv
// ----------------------------------------------------------------------------
// srrs_step
// Next-state and record logic for one character of the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module srrs_step #(
    parameter int POSITION_BITS = 20
) (
    input  wire srrs_pkg::t_phase           i_phase,
    input  wire logic [1:0]                 i_hdr_idx,
    input  wire logic [31:0]                i_name,
    input  wire logic [7:0]                 i_chain,
    input  wire logic [POSITION_BITS-1:0]   i_count,
    input  wire logic [23:0]                i_buf,
    input  wire logic [7:0]                 i_char,
    output srrs_pkg::t_phase                o_phase,
    output logic [1:0]                      o_hdr_idx,
    output logic [31:0]                     o_name,
    output logic [7:0]                      o_chain,
    output logic [POSITION_BITS-1:0]        o_count,
    output logic [23:0]                     o_buf,
    output srrs_pkg::t_rec                  o_rec
);
    import srrs_pkg::*;

    logic                                   is_sm;
    logic [POSITION_BITS-1:0]               cnt_inc;
    logic [1:0]                             back;
    logic [POSITION_BITS-1:0]               back_ext;
    logic [POSITION_BITS-1:0]               diff;
    logic [POSITION_BITS+START_BITS-1:0]    diff_wide;

    assign is_sm = is_small(i_char);

    // position count saturates at all ones, newlines not counted
    assign cnt_inc = ((i_char != CH_NEWLINE) && !(&i_count)) ? i_count + 1'b1 : i_count;

    // only a run of two closes in the third-byte phase
    assign back      = (i_phase == PH_THIRD) ? BACK_TWO : BACK_THREE;
    assign back_ext  = {{(POSITION_BITS-2){1'b0}}, back};
    assign diff      = (cnt_inc >= back_ext) ? cnt_inc - back_ext : '0;
    assign diff_wide = {{START_BITS{1'b0}}, diff};

    always_comb begin
        o_phase        = i_phase;
        o_hdr_idx      = i_hdr_idx;
        o_name         = i_name;
        o_chain        = i_chain;
        o_count        = i_count;
        o_buf          = i_buf;
        o_rec.vld      = 1'b0;
        o_rec.residues = '0;
        o_rec.length   = LEN_THREE;
        o_rec.start    = diff_wide[START_BITS-1:0];

        case (i_phase)
            PH_NAME: begin
                o_name[{i_hdr_idx, 3'b000} +: 8] = i_char;
                if (i_hdr_idx == 2'd3) begin
                    o_hdr_idx = 2'd0;
                    o_phase   = PH_CHAIN;
                end else begin
                    o_hdr_idx = i_hdr_idx + 2'd1;
                end
            end
            PH_CHAIN: begin
                o_chain = i_char;
                o_phase = PH_SKIP;
            end
            PH_SKIP: begin
                if (i_char == CH_NEWLINE) begin
                    o_phase = PH_FIRST;
                end
            end
            PH_SECOND: begin
                o_count = cnt_inc;
                if (is_sm) begin
                    o_buf[15:8] = i_char;
                    o_phase     = PH_THIRD;
                end else begin
                    o_buf   = '0;
                    o_phase = PH_FIRST;
                end
            end
            PH_THIRD: begin
                o_count = cnt_inc;
                if (is_sm) begin
                    o_buf[23:16] = i_char;
                    o_phase      = PH_FOURTH;
                end else begin
                    o_rec.vld      = 1'b1;
                    o_rec.residues = {16'b0, i_buf[15:0]};
                    o_rec.length   = LEN_TWO;
                    o_buf          = '0;
                    o_phase        = PH_FIRST;
                end
            end
            PH_FOURTH: begin
                o_count   = cnt_inc;
                o_rec.vld = 1'b1;
                if (is_sm) begin
                    o_rec.residues = {i_char, i_buf};
                    o_rec.length   = LEN_FOUR;
                end else begin
                    o_rec.residues = {8'b0, i_buf};
                    o_rec.length   = LEN_THREE;
                end
                o_buf   = '0;
                o_phase = PH_FIRST;
            end
            default: begin
                // group start, also recovers from a bad phase code
                o_phase = PH_FIRST;
                if (i_char == CH_HEADER) begin
                    o_count   = '0;
                    o_name    = '0;
                    o_hdr_idx = 2'd0;
                    o_phase   = PH_NAME;
                end else begin
                    o_count = cnt_inc;
                    if (is_sm) begin
                        o_buf   = {16'b0, i_char};
                        o_phase = PH_SECOND;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/small_residue_run_scanner_core.sv
// ----------------------------------------------------------------------------
// small_residue_run_scanner_core
// Scans a FASTA byte stream and reports runs of two to four small residues.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  input    in         i_valid / o_ready   i_char_code
//  result   out        o_valid / i_ready   o_run_residues, o_run_length,
//                                          o_protein_id, o_chain_code,
//                                          o_start_position
//
//  one character per clock while o_ready is high; the scan state updates on the accepting edge
//  a record shows on the outputs the cycle after the character that closes it
//  o_ready stays high while the result register is empty or being drained,
//  so a word can be taken every cycle with the output side ready
//  synchronous active-low reset returns the scanner to group start, count zero
// ----------------------------------------------------------------------------
`default_nettype none

module small_residue_run_scanner_core #(
    parameter int POSITION_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_run_residues,
    output logic [2:0]       o_run_length,
    output logic [31:0]      o_protein_id,
    output logic [7:0]       o_chain_code,
    output logic [19:0]      o_start_position
);
    import srrs_pkg::*;

    t_phase                   r_phase,   n_phase;
    logic [1:0]               r_hdr_idx, n_hdr_idx;
    logic [31:0]              r_name,    n_name;
    logic [7:0]               r_chain,   n_chain;
    logic [POSITION_BITS-1:0] r_count,   n_count;
    logic [23:0]              r_buf,     n_buf;
    t_rec                     n_rec;

    logic                     r_out_valid;
    logic [31:0]              r_out_residues;
    logic [2:0]               r_out_length;
    logic [31:0]              r_out_name;
    logic [7:0]               r_out_chain;
    logic [START_BITS-1:0]    r_out_start;

    logic                     in_fire;

    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    srrs_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .i_phase   (r_phase),
        .i_hdr_idx (r_hdr_idx),
        .i_name    (r_name),
        .i_chain   (r_chain),
        .i_count   (r_count),
        .i_buf     (r_buf),
        .i_char    (i_char_code),
        .o_phase   (n_phase),
        .o_hdr_idx (n_hdr_idx),
        .o_name    (n_name),
        .o_chain   (n_chain),
        .o_count   (n_count),
        .o_buf     (n_buf),
        .o_rec     (n_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FIRST;
            r_hdr_idx <= '0;
            r_name    <= '0;
            r_chain   <= '0;
            r_count   <= '0;
            r_buf     <= '0;
        end else if (in_fire) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_name    <= n_name;
            r_chain   <= n_chain;
            r_count   <= n_count;
            r_buf     <= n_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= in_fire && n_rec.vld;
        end
    end

    // record payload; name and chain are stable while a run is open
    always_ff @(posedge i_clk) begin
        if (in_fire && n_rec.vld) begin
            r_out_residues <= n_rec.residues;
            r_out_length   <= n_rec.length;
            r_out_start    <= n_rec.start;
            r_out_name     <= r_name;
            r_out_chain    <= r_chain;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_run_residues   = r_out_residues;
    assign o_run_length     = r_out_length;
    assign o_protein_id     = r_out_name;
    assign o_chain_code     = r_out_chain;
    assign o_start_position = r_out_start;

endmodule

`default_nettype wire

// File: hdl/srrs_checker.sv
// ----------------------------------------------------------------------------
// srrs_checker
// Port-level checks for the small residue run scanner, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module srrs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_run_residues,
    input wire logic [2:0]  o_run_length,
    input wire logic [31:0] o_protein_id,
    input wire logic [7:0]  o_chain_code,
    input wire logic [19:0] o_start_position
);

    // a held word keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_run_residues)
            && $stable(o_run_length) && $stable(o_start_position)
            && $stable(o_protein_id) && $stable(o_chain_code))
        else $error("result word changed while stalled");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_run_length == 3'd2) || (o_run_length == 3'd3)
            || (o_run_length == 3'd4))
        else $error("run length out of range");

    // bytes past the run length read zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_run_length != 3'd2) || (o_run_residues[31:16] == 16'h0000))
            && ((o_run_length != 3'd3) || (o_run_residues[31:24] == 8'h00)))
        else $error("unused residue bytes not zero");

    // full result register with a stalled consumer blocks the input
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted over a stalled result");

    // a new result only follows an accepted character
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready))
        else $error("result without an accepted character");

endmodule

bind small_residue_run_scanner_core srrs_checker u_srrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_run_residues   (o_run_residues),
    .o_run_length     (o_run_length),
    .o_protein_id     (o_protein_id),
    .o_chain_code     (o_chain_code),
    .o_start_position (o_start_position)
);

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the small residue run scanner core: a short
// directed table, then random FASTA-like text with one long output stall
// and a stretch at full rate. Every run record is checked, in order, field by
// field, against its typed table row or an in-bench scanner model.
// ----------------------------------------------------------------------------
module testbench;
    import srrs_pkg::*;

    localparam int POS_BITS    = 20;
    localparam int RAND_ITEMS  = 1800;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 200000;

    typedef struct packed {
        logic [31:0]         residues;
        logic [2:0]          length;
        logic [31:0]         protein;
        logic [7:0]          chain;
        logic [START_BITS-1:0] start;
    } t_run_record;

    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        t_run_record run;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_char_code = 8'h00;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_run_residues;
    logic [2:0]  o_run_length;
    logic [31:0] o_protein_id;
    logic [7:0]  o_chain_code;
    logic [19:0] o_start_position;

    small_residue_run_scanner_core #(
        .POSITION_BITS(POS_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_code     (i_char_code),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_run_residues  (o_run_residues),
        .o_run_length    (o_run_length),
        .o_protein_id    (o_protein_id),
        .o_chain_code    (o_chain_code),
        .o_start_position(o_start_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // scanner model state
    t_phase              sc_phase = PH_FIRST;
    logic [1:0]          sc_index = '0;
    logic [31:0]         sc_name  = '0;
    logic [7:0]          sc_chain = '0;
    logic [POS_BITS-1:0] sc_count = '0;
    logic [23:0]         sc_buf   = '0;

    t_run_record pending_runs[$];
    t_script_row script[$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;
    int items_sent = 0;
    int runs_seen  = 0;
    int bad_count  = 0;
    int cycle_count = 0;
    int len_hits[5] = '{0, 0, 0, 0, 0};

    function automatic bit small_residue(input logic [7:0] c);
        case (c)
            CH_G, CH_A, CH_S, CH_T, CH_C: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] pick_small();
        case ($urandom_range(4))
            0: return CH_G;
            1: return CH_A;
            2: return CH_S;
            3: return CH_T;
            default: return CH_C;
        endcase
    endfunction

    function automatic t_run_record close_run(input logic [31:0] residues,
                                              input logic [2:0] len,
                                              input logic [1:0] back);
        t_run_record r;
        r.residues = residues;
        r.length   = len;
        r.protein  = sc_name;
        r.chain    = sc_chain;
        r.start    = (sc_count >= back) ? START_BITS'(sc_count - back) : '0;
        return r;
    endfunction

    task automatic count_char(input logic [7:0] c);
        if (c != CH_NEWLINE && sc_count != {POS_BITS{1'b1}}) begin
            sc_count = sc_count + 1'b1;
        end
    endtask

    task automatic scan_char(input logic [7:0] c, output bit hit, output t_run_record r);
        hit = 1'b0;
        r   = '0;
        case (sc_phase)
            PH_NAME: begin
                sc_name = sc_name | (32'(c) << (8 * sc_index));
                if (sc_index == 2'd3) begin
                    sc_index = '0;
                    sc_phase = PH_CHAIN;
                end else begin
                    sc_index = sc_index + 1'b1;
                end
            end
            PH_CHAIN: begin
                sc_chain = c;
                sc_phase = PH_SKIP;
            end
            PH_SKIP: begin
                if (c == CH_NEWLINE) sc_phase = PH_FIRST;
            end
            PH_SECOND: begin
                count_char(c);
                if (small_residue(c)) begin
                    sc_buf[15:8] = c;
                    sc_phase = PH_THIRD;
                end else begin
                    sc_buf   = '0;
                    sc_phase = PH_FIRST;
                end
            end
            PH_THIRD: begin
                count_char(c);
                if (small_residue(c)) begin
                    sc_buf[23:16] = c;
                    sc_phase = PH_FOURTH;
                end else begin
                    hit = 1'b1;
                    r = close_run({16'h0, sc_buf[15:0]}, LEN_TWO, BACK_TWO);
                    sc_buf   = '0;
                    sc_phase = PH_FIRST;
                end
            end
            PH_FOURTH: begin
                count_char(c);
                hit = 1'b1;
                // the chunk always closes on its fourth byte
                if (small_residue(c)) r = close_run({c, sc_buf}, LEN_FOUR, BACK_THREE);
                else r = close_run({8'h0, sc_buf}, LEN_THREE, BACK_THREE);
                sc_buf   = '0;
                sc_phase = PH_FIRST;
            end
            default: begin
                sc_phase = PH_FIRST;
                if (c == CH_HEADER) begin
                    sc_count = '0;
                    sc_name  = '0;
                    sc_index = '0;
                    sc_phase = PH_NAME;
                end else begin
                    count_char(c);
                    if (small_residue(c)) begin
                        sc_buf   = {16'h0, c};
                        sc_phase = PH_SECOND;
                    end
                end
            end
        endcase
    endtask

    // offer one word, wait for it to be taken, then predict its record
    task automatic put_char(input logic [7:0] c, input bit typed, input t_run_record typed_run);
        bit          hit;
        t_run_record r;
        while (tx_idle_on && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        scan_char(c, hit, r);
        if (typed) pending_runs = {pending_runs, typed_run};
        else if (hit) pending_runs = {pending_runs, r};
    endtask

    function automatic logic [7:0] text_char();
        int k;
        k = $urandom_range(99);
        if (k < 50) return pick_small();
        if (k < 78) return 8'($urandom_range(8'h5a, 8'h41));
        if (k < 86) return CH_NEWLINE;
        if (k < 90) return CH_HEADER;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_header();
        put_char(CH_HEADER, 1'b0, '0);
        repeat (5) begin
            if ($urandom_range(99) < 8) put_char(8'($urandom_range(255)), 1'b0, '0);
            else put_char(8'($urandom_range(8'h5a, 8'h30)), 1'b0, '0);
        end
        repeat ($urandom_range(3)) put_char(8'($urandom_range(8'h7a, 8'h20)), 1'b0, '0);
        put_char(CH_NEWLINE, 1'b0, '0);
    endtask

    task automatic send_line();
        repeat ($urandom_range(40, 3)) put_char(text_char(), 1'b0, '0);
        put_char(CH_NEWLINE, 1'b0, '0);
    endtask

    task automatic add_row(input logic [7:0] c, input bit typed, input t_run_record r);
        t_script_row row;
        row.ch    = c;
        row.typed = typed;
        row.run   = r;
        script = {script, row};
    endtask

    task automatic check_run();
        t_run_record seen;
        t_run_record want;
        seen = {o_run_residues, o_run_length, o_protein_id, o_chain_code, o_start_position};
        if (pending_runs.size() == 0) begin
            bad_count++;
            if (bad_count <= 10) begin
                $display("unexpected record: res %h len %0d id %h chain %h start %0d",
                         seen.residues, seen.length, seen.protein, seen.chain, seen.start);
            end
        end else begin
            want = pending_runs.pop_front();
            runs_seen++;
            if (want.length <= 3'd4) len_hits[want.length]++;
            if (seen.residues !== want.residues || seen.length !== want.length ||
                seen.protein !== want.protein || seen.chain !== want.chain ||
                seen.start !== want.start) begin
                bad_count++;
                if (bad_count <= 10) begin
                    $display("record %0d: exp res %h len %0d id %h chain %h start %0d",
                             runs_seen, want.residues, want.length, want.protein,
                             want.chain, want.start);
                    $display("record %0d: got res %h len %0d id %h chain %h start %0d",
                             runs_seen, seen.residues, seen.length, seen.protein,
                             seen.chain, seen.start);
                end
            end
        end
    endtask

    // result side, with its own random stalls and one long hold-off
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) check_run();
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !(rx_idle_on && $urandom_range(99) < 37);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles, %0d records outstanding",
                     cycle_count, pending_runs.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        int  rand_base;
        bit  hold_done;
        hold_done = 1'b0;

        // directed table: typed rows hold records that follow directly
        // from reset or from the header just above them
        add_row(CH_G, 1'b0, '0);
        add_row(CH_A, 1'b0, '0);
        add_row(CH_NEWLINE, 1'b1, {32'h0000_4147, LEN_TWO, 32'h0, 8'h00, 20'd0});
        // header with a newline inside the name and as the subunit
        add_row(CH_HEADER, 1'b0, '0);
        add_row(8'h4E, 1'b0, '0);
        add_row(CH_NEWLINE, 1'b0, '0);
        add_row(8'h51, 1'b0, '0);
        add_row(8'h52, 1'b0, '0);
        add_row(CH_NEWLINE, 1'b0, '0);
        add_row(CH_NEWLINE, 1'b0, '0);
        add_row(CH_T, 1'b0, '0);
        add_row(CH_T, 1'b0, '0);
        add_row(CH_T, 1'b0, '0);
        add_row(CH_T, 1'b1, {32'h5454_5454, LEN_FOUR, 32'h5251_0A4E, 8'h0A, 20'd1});
        // header mark inside a chunk counts and closes it
        add_row(CH_S, 1'b0, '0);
        add_row(CH_C, 1'b0, '0);
        add_row(CH_G, 1'b0, '0);
        add_row(CH_HEADER, 1'b0, '0);
        add_row(CH_A, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);
        add_row(CH_C, 1'b0, '0);
        add_row(CH_NEWLINE, 1'b0, '0);
        add_row(8'hFF, 1'b0, '0);
        add_row(8'h00, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < script.size(); i++) begin
            put_char(script[i].ch, script[i].typed, script[i].run);
        end

        rand_base = items_sent;
        while (items_sent - rand_base < RAND_ITEMS) begin
            if ($urandom_range(9) != 0) send_header();
            repeat ($urandom_range(4, 1)) send_line();
            if (!hold_done && items_sent - rand_base > 600) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            // a long quiet stretch with both sides at full rate
            tx_idle_on = !(items_sent - rand_base > 1000 && items_sent - rand_base < 1400);
            rx_idle_on = tx_idle_on;
        end
        i_valid <= 1'b0;

        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (pending_runs.size() != 0) bad_count++;

        $display("scanned %0d characters of headers and sequence lines, with idles and stalls",
                 items_sent);
        $display("checked %0d run records: %0d of two, %0d of three, %0d of four residues",
                 runs_seen, len_hits[2], len_hits[3], len_hits[4]);
        if (bad_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
